>>> design/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg: shared types and constants for the metronome click generator
// Holds the sequencer states, register indexes, configuration bundle and
// the reset values and the fixed amplitude, envelope, beat and multiplier constants.
// ----------------------------------------------------------------------------
package mcg_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ENABLE            = 3'd0,
    REG_SAMPLES_PER_BEAT  = 3'd1,
    REG_BEATS_PER_BAR     = 3'd2,
    REG_CLICK_GAIN        = 3'd3,
    REG_CLICK_LENGTH      = 3'd4,
    REG_DECAY_FACTOR      = 3'd5,
    REG_ACCENT_PHASE_STEP = 3'd6,
    REG_NORMAL_PHASE_STEP = 3'd7
  } reg_index_t;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEAT,
    ST_WRAP,
    ST_INDEX,
    ST_FETCH,
    ST_ENV_MUL,
    ST_AMP_MUL,
    ST_GAIN_MUL,
    ST_MIX,
    ST_UPDATE,
    ST_DONE
  } seq_state_t;

  // Live configuration registers
  typedef struct packed {
    logic        enable;
    logic [31:0] samples_per_beat;
    logic [6:0]  beats_per_bar;
    logic [15:0] click_gain;
    logic [15:0] click_length;
    logic [15:0] decay_factor;
    logic [31:0] accent_phase_step;
    logic [31:0] normal_phase_step;
  } cfg_t;

  // Reset values of the configuration registers
  localparam logic [31:0] RST_SAMPLES_PER_BEAT  = 32'd6144000;
  localparam logic [6:0]  RST_BEATS_PER_BAR     = 7'd4;
  localparam logic [15:0] RST_CLICK_GAIN        = 16'd4096;
  localparam logic [15:0] RST_CLICK_LENGTH      = 16'd2400;
  localparam logic [15:0] RST_DECAY_FACTOR      = 16'd65422;
  localparam logic [31:0] RST_ACCENT_PHASE_STEP = 32'd134217728;
  localparam logic [31:0] RST_NORMAL_PHASE_STEP = 32'd89478485;

  // Click amplitudes in Q0.16: 1.0 for accented, 0.6 for normal beats
  localparam logic [15:0] AMP_ACCENT = 16'd65535;
  localparam logic [15:0] AMP_NORMAL = 16'd39322;

  // Envelope start level and the full-scale sine value at the table edge
  localparam logic [15:0] ENV_FULL  = 16'hFFFF;
  localparam logic [15:0] SINE_PEAK = 16'hFFFF;

  // Beat accumulator in Q32.8 against a period in Q24.8: one sample is 1.0, period floor is one sample
  localparam int          BEAT_PHASE_W = 40;
  localparam logic [31:0] MIN_PERIOD   = 32'd256;
  localparam logic [6:0]  MAX_BPB      = 7'd64;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

>>> design/mcg_stream_if.sv
// ----------------------------------------------------------------------------
// mcg_stream_if: valid/ready channels of the metronome click generator
// Sample channel into the block and mixed result channel out of it.
// ----------------------------------------------------------------------------
interface mcg_in_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface mcg_out_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           click_started;
  logic                           accent_beat;

  modport source (output valid, output out_sample, output click_started,
                  output accent_beat, input ready);
  modport sink   (input valid, input out_sample, input click_started,
                  input accent_beat, output ready);
endinterface

>>> design/mcg_mul.sv
// ----------------------------------------------------------------------------
// mcg_mul: shared unsigned multiplier
// One registered 32x16 product per cycle; the sequencer feeds it in turn.
// ----------------------------------------------------------------------------
module mcg_mul
  import mcg_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [MUL_P_W-1:0] prod
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

endmodule

>>> design/mcg_sine_rom.sv
// ----------------------------------------------------------------------------
// mcg_sine_rom: quarter-wave sine table
// Entry i holds sin(pi/2 * i / DEPTH) in Q0.16, built at elaboration from a
// fixed-point odd polynomial; read data is registered.
// ----------------------------------------------------------------------------
module mcg_sine_rom
  import mcg_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [15:0]       data
);

  typedef logic [15:0] rom_t [DEPTH];

  // Evaluate the polynomial in Q30 with Horner's rule
  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] s;
    for (int i = 0; i < DEPTH; i++) begin
      u  = (64'(i) << 30) / 64'(DEPTH);
      u2 = (u * u) >> 30;
      s  = 64'd3864;
      s  = 64'd172272 - ((s * u2) >> 30);
      s  = 64'd5026996 - ((s * u2) >> 30);
      s  = 64'd85569307 - ((s * u2) >> 30);
      s  = 64'd693598669 - ((s * u2) >> 30);
      s  = 64'd1686629713 - ((s * u2) >> 30);
      s  = (s * u) >> 30;
      s  = (s + 64'd8192) >> 14;
      t[i] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
    end
    return t;
  endfunction

  localparam rom_t SINE = build_rom();

  // Registered read
  always_ff @(posedge clk) begin
    data <= SINE[addr];
  end

endmodule

>>> design/mcg_ctrl.sv
// ----------------------------------------------------------------------------
// mcg_ctrl: beat tracking and click rendering sequencer
// Walks one request through beat update, sine lookup and four chained
// products on the shared multiplier, then mixes and saturates the result.
// ----------------------------------------------------------------------------
module mcg_ctrl
  import mcg_pkg::*;
#(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int ADDR_W           = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  mcg_in_if.sink             samples,
  mcg_out_if.source          results,
  output logic [MUL_A_W-1:0] mul_a,
  output logic [MUL_B_W-1:0] mul_b,
  input  logic [MUL_P_W-1:0] mul_p,
  output logic [ADDR_W-1:0]  rom_addr,
  input  logic [15:0]        rom_data
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int M_W     = 20;              // click magnitude after gain
  localparam int DELTA_W = M_W + SW - 1 - 16;
  localparam int SUM_W   = SW + 5;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {6'b000000, {(SW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {6'b111111, {(SW-1){1'b0}}};

  seq_state_t state, state_next;

  // Request and result holding registers
  logic signed [SW-1:0] x;
  logic signed [SW-1:0] mix;
  logic                 started_r;
  logic                 accent_r;

  // Beat and click state
  logic                    started_flag;
  logic [BEAT_PHASE_W-1:0] beat_phase;
  logic [5:0]              beat_in_bar;
  logic                    click_active;
  logic [15:0]             click_count;
  logic [31:0]             osc_phase;
  logic [15:0]             env_level;
  logic                    accent_click;
  logic                    rom_peak;

  // Output register
  logic                 res_valid;
  logic signed [SW-1:0] res_sample;
  logic                 res_started;
  logic                 res_accent;

  logic                    cfg_live;
  logic [BEAT_PHASE_W-1:0] period;
  logic [6:0]              bpb;
  logic                    beat_hit;
  logic [6:0]              bar_inc;
  logic [5:0]              bar_next;
  logic [ADDR_W-1:0]       idx;
  logic [M_W-1:0]          mag;
  logic [M_W+SW-2:0]       mag_wide;
  logic [DELTA_W-1:0]      delta;
  logic signed [SUM_W-1:0] x_ext;
  logic signed [SUM_W-1:0] delta_ext;
  logic signed [SUM_W-1:0] sum;
  logic [16:0]             count_inc;
  logic                    out_free;

  // Decode live configuration
  always_comb begin
    cfg_live = cfg.enable && (cfg.samples_per_beat != '0);
    period   = (cfg.samples_per_beat < MIN_PERIOD) ? BEAT_PHASE_W'(MIN_PERIOD)
                                                   : BEAT_PHASE_W'(cfg.samples_per_beat);
    if (cfg.beats_per_bar == '0) begin
      bpb = 7'd1;
    end else if (cfg.beats_per_bar > MAX_BPB) begin
      bpb = MAX_BPB;
    end else begin
      bpb = cfg.beats_per_bar;
    end
  end

  // Beat wrap, bar advance and mix arithmetic
  always_comb begin
    beat_hit  = beat_phase >= period;
    bar_inc   = {1'b0, beat_in_bar} + 7'd1;
    bar_next  = (bar_inc >= bpb) ? 6'd0 : bar_inc[5:0];
    idx       = mul_p[30 +: ADDR_W];
    mag       = mul_p[12 +: M_W];
    mag_wide  = {mag, {(SW-1){1'b0}}};
    delta     = mag_wide[M_W+SW-2:16];
    x_ext     = SUM_W'(x);
    delta_ext = SUM_W'($signed({2'b00, delta}));
    sum       = osc_phase[31] ? (x_ext - delta_ext) : (x_ext + delta_ext);
    count_inc = {1'b0, click_count} + 17'd1;
    out_free  = !res_valid || results.ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          state_next = cfg_live ? ST_BEAT : ST_DONE;
        end
      end
      ST_BEAT: begin
        state_next = started_flag ? ST_WRAP : ST_INDEX;
      end
      ST_WRAP: begin
        state_next = (beat_hit || click_active) ? ST_INDEX : ST_DONE;
      end
      ST_INDEX:    state_next = ST_FETCH;
      ST_FETCH:    state_next = ST_ENV_MUL;
      ST_ENV_MUL:  state_next = ST_AMP_MUL;
      ST_AMP_MUL:  state_next = ST_GAIN_MUL;
      ST_GAIN_MUL: state_next = ST_MIX;
      ST_MIX:      state_next = ST_UPDATE;
      ST_UPDATE:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Multiplier operands, table address and handshake outputs
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = idx;
    unique case (state)
      ST_INDEX: begin
        mul_a = MUL_A_W'(osc_phase[29:0]);
        mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      ST_FETCH: begin
        if (osc_phase[30]) begin
          rom_addr = ADDR_W'(SINE_TABLE_DEPTH - int'(idx));
        end
      end
      ST_ENV_MUL: begin
        mul_a = MUL_A_W'(rom_peak ? SINE_PEAK : rom_data);
        mul_b = env_level;
      end
      ST_AMP_MUL: begin
        mul_a = MUL_A_W'(mul_p[31:16]);
        mul_b = accent_click ? AMP_ACCENT : AMP_NORMAL;
      end
      ST_GAIN_MUL: begin
        mul_a = MUL_A_W'(mul_p[31:16]);
        mul_b = cfg.click_gain;
      end
      ST_MIX: begin
        mul_a = MUL_A_W'(env_level);
        mul_b = cfg.decay_factor;
      end
      default: begin
      end
    endcase
  end

  assign samples.ready         = (state == ST_IDLE);
  assign results.valid         = res_valid;
  assign results.out_sample    = res_sample;
  assign results.click_started = res_started;
  assign results.accent_beat   = res_accent;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Update beat and click state
  always_ff @(posedge clk) begin
    if (rst) begin
      started_flag <= 1'b0;
      beat_phase   <= '0;
      beat_in_bar  <= '0;
      click_active <= 1'b0;
      click_count  <= '0;
      osc_phase    <= '0;
      env_level    <= '0;
      accent_click <= 1'b0;
    end else begin
      unique case (state)
        ST_BEAT: begin
          if (!started_flag) begin
            started_flag <= 1'b1;
            click_active <= 1'b1;
            click_count  <= '0;
            osc_phase    <= '0;
            env_level    <= ENV_FULL;
            accent_click <= 1'b1;
          end else begin
            beat_phase <= beat_phase + BEAT_PHASE_W'(MIN_PERIOD);
          end
        end
        ST_WRAP: begin
          if (beat_hit) begin
            beat_phase   <= beat_phase - period;
            beat_in_bar  <= bar_next;
            click_active <= 1'b1;
            click_count  <= '0;
            osc_phase    <= '0;
            env_level    <= ENV_FULL;
            accent_click <= (bar_next == 6'd0);
          end
        end
        ST_UPDATE: begin
          env_level    <= mul_p[31:16];
          osc_phase    <= osc_phase + (accent_click ? cfg.accent_phase_step
                                                    : cfg.normal_phase_step);
          click_active <= !(count_inc >= {1'b0, cfg.click_length});
          click_count  <= count_inc[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the request sample, beat flags and mixed value
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (samples.valid) begin
          x         <= samples.in_sample;
          mix       <= samples.in_sample;
          started_r <= 1'b0;
          accent_r  <= 1'b0;
        end
      end
      ST_BEAT: begin
        if (!started_flag) begin
          started_r <= 1'b1;
          accent_r  <= 1'b1;
        end
      end
      ST_WRAP: begin
        if (beat_hit) begin
          started_r <= 1'b1;
          accent_r  <= (bar_next == 6'd0);
        end
      end
      ST_FETCH: begin
        rom_peak <= osc_phase[30] && (idx == '0);
      end
      ST_MIX: begin
        if (sum > SUM_MAX) begin
          mix <= SUM_MAX[SW-1:0];
        end else if (sum < SUM_MIN) begin
          mix <= SUM_MIN[SW-1:0];
        end else begin
          mix <= sum[SW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      res_sample  <= mix;
      res_started <= started_r;
      res_accent  <= accent_r;
    end
  end

endmodule

>>> design/metronome_click_generator_core.sv
// ----------------------------------------------------------------------------
// metronome_click_generator_core: adds a metronome click to an audio stream
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   in_sample
//   results   out  valid/ready   out_sample, click_started, accent_beat
//   cfg       in   cfg_wr_en     cfg_index, cfg_data
//
// A sample with a click sounding walks every state from beat through update to
// done between acceptances; the first enabled sample after reset skips the wrap
// check. Its result enters the output register as the sequencer leaves done.
// Five products go in turn to the one shared multiplier. Disabled, a sample goes
// straight to done; enabled with no click sounding, it passes beat and wrap only.
// Input ready is high only while the sequencer is idle; a held result in the
// output register does not block the next sample until it is finished.
// Synchronous reset clears beat state and restores register defaults.
// ----------------------------------------------------------------------------
module metronome_click_generator_core
  import mcg_pkg::*;
#(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  mcg_in_if.sink                 samples,
  mcg_out_if.source              results,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

  cfg_t               cfg;
  reg_index_t         cfg_sel;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [ADDR_W-1:0]  rom_addr;
  logic [15:0]        rom_data;

  assign cfg_sel = reg_index_t'(cfg_index);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable            <= 1'b0;
      cfg.samples_per_beat  <= RST_SAMPLES_PER_BEAT;
      cfg.beats_per_bar     <= RST_BEATS_PER_BAR;
      cfg.click_gain        <= RST_CLICK_GAIN;
      cfg.click_length      <= RST_CLICK_LENGTH;
      cfg.decay_factor      <= RST_DECAY_FACTOR;
      cfg.accent_phase_step <= RST_ACCENT_PHASE_STEP;
      cfg.normal_phase_step <= RST_NORMAL_PHASE_STEP;
    end else if (cfg_wr_en) begin
      unique case (cfg_sel)
        REG_ENABLE:            cfg.enable            <= cfg_data[0];
        REG_SAMPLES_PER_BEAT:  cfg.samples_per_beat  <= cfg_data;
        REG_BEATS_PER_BAR:     cfg.beats_per_bar     <= cfg_data[6:0];
        REG_CLICK_GAIN:        cfg.click_gain        <= cfg_data[15:0];
        REG_CLICK_LENGTH:      cfg.click_length      <= cfg_data[15:0];
        REG_DECAY_FACTOR:      cfg.decay_factor      <= cfg_data[15:0];
        REG_ACCENT_PHASE_STEP: cfg.accent_phase_step <= cfg_data;
        REG_NORMAL_PHASE_STEP: cfg.normal_phase_step <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  mcg_ctrl #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .ADDR_W           (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .samples  (samples),
    .results  (results),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_p    (mul_p),
    .rom_addr (rom_addr),
    .rom_data (rom_data)
  );

  // Shared multiplier
  mcg_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // Quarter-wave sine table
  mcg_sine_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the metronome click generator core
// Drives audio samples and register writes, predicts every mixed sample,
// beat flag and accent flag, and compares each result in order. A short
// directed table walks the extremes and corner settings, then random phases
// reprogram all registers and push samples under varied idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import mcg_pkg::*;

  localparam int SMP_W        = 24;
  localparam int TABLE_DEPTH  = 256;
  localparam int SETTLE_CYC   = 16;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 66;
  localparam longint SMP_MAX  = (64'sd1 <<< (SMP_W - 1)) - 1;
  localparam longint SMP_MIN  = -SMP_MAX - 1;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_sample;
    logic                    click_started;
    logic                    accent_beat;
  } mix_t;

  // Typed expectation carried with a request, if the row has one
  typedef struct packed {
    bit   typed;
    mix_t want;
  } stim_tag_t;

  typedef struct packed {
    bit                      is_cfg;
    reg_index_t              idx;
    logic [CFG_DATA_W-1:0]   val;
    logic signed [SMP_W-1:0] smp;
    bit                      typed;
    mix_t                    want;
  } dir_row_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mcg_in_if  #(.SAMPLE_WIDTH(SMP_W)) smp_if ();
  mcg_out_if #(.SAMPLE_WIDTH(SMP_W)) res_if ();

  metronome_click_generator_core #(
    .SAMPLE_WIDTH    (SMP_W),
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (smp_if),
    .results  (res_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Register copy and click state of the predictor
  cfg_t         cfg_m;
  bit           begun_q;
  bit [39:0]    beat_acc;
  bit [5:0]     bar_pos;
  bit           tone_on;
  bit [15:0]    tone_cnt;
  bit [31:0]    tone_ph;
  bit [15:0]    env_lvl;
  bit           tone_acc;
  bit [15:0]    sine_tab [TABLE_DEPTH];

  mix_t         mix_expect_q [$];
  stim_tag_t    sent_tag_q [$];
  dir_row_t     dir_rows [$];
  idle_mode_t   idle_mode;
  bit           cfg_open;
  int           mismatch_cnt;
  int           cycle_cnt;

  // Quarter-wave sine entry in Q0.16 from a Horner polynomial in Q30
  function automatic logic [15:0] quarter_sine(input int unsigned i);
    longint unsigned u, u2, s;
    u  = 64'(i);
    u  = (u << 30) / TABLE_DEPTH;
    u2 = (u * u) >> 30;
    s  = 64'd3864;
    s  = 64'd172272 - ((s * u2) >> 30);
    s  = 64'd5026996 - ((s * u2) >> 30);
    s  = 64'd85569307 - ((s * u2) >> 30);
    s  = 64'd693598669 - ((s * u2) >> 30);
    s  = 64'd1686629713 - ((s * u2) >> 30);
    s  = (s * u) >> 30;
    s  = (s + 64'd8192) >> 14;
    return (s > 64'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  // Sine magnitude for an oscillator phase; neg marks the lower half
  function automatic longint unsigned sine_mag(input bit [31:0] ph, output bit neg);
    longint unsigned frac, idx;
    bit [15:0]       v;
    frac = 64'(ph[29:0]);
    idx  = (frac * TABLE_DEPTH) >> 30;
    if (idx >= TABLE_DEPTH) idx = 64'(TABLE_DEPTH - 1);
    if (ph[30]) v = (idx == 0) ? SINE_PEAK : sine_tab[TABLE_DEPTH - idx];
    else v = sine_tab[idx];
    neg = ph[31];
    return 64'(v);
  endfunction

  function automatic void begin_click(input bit acc);
    tone_on  = 1'b1;
    tone_cnt = '0;
    tone_ph  = '0;
    env_lvl  = ENV_FULL;
    tone_acc = acc;
  endfunction

  // Mixed output for one accepted sample; advances the click state
  function automatic mix_t click_mix_predict(input logic signed [SMP_W-1:0] x);
    mix_t            r;
    longint          sum, delta;
    longint unsigned period, m;
    int unsigned     bpb, nxt, cnt;
    bit              neg;
    r   = '0;
    sum = 64'(x);
    if (cfg_m.enable && cfg_m.samples_per_beat != 0) begin
      period = (cfg_m.samples_per_beat < MIN_PERIOD) ? 64'(MIN_PERIOD)
                                                     : 64'(cfg_m.samples_per_beat);
      bpb = (cfg_m.beats_per_bar == 0) ? 1 :
            ((cfg_m.beats_per_bar > MAX_BPB) ? 32'(MAX_BPB) : 32'(cfg_m.beats_per_bar));
      // Beat tracking: first sample fires an accented click
      if (!begun_q) begin
        begun_q = 1'b1;
        begin_click(1'b1);
        r.click_started = 1'b1;
        r.accent_beat   = 1'b1;
      end else begin
        beat_acc = beat_acc + 40'd256;
        if (beat_acc >= period) begin
          beat_acc = beat_acc - period[39:0];
          nxt = bar_pos + 1;
          if (nxt >= bpb) nxt = 0;
          bar_pos = nxt[5:0];
          r.click_started = 1'b1;
          r.accent_beat   = (bar_pos == 0);
          begin_click(bar_pos == 0);
        end
      end
      // Render the sounding click and advance oscillator and envelope
      if (tone_on) begin
        m = sine_mag(tone_ph, neg);
        m = (m * env_lvl) >> 16;
        m = (m * (tone_acc ? AMP_ACCENT : AMP_NORMAL)) >> 16;
        m = (m * cfg_m.click_gain) >> 12;
        m = (m << (SMP_W - 1)) >> 16;
        delta = longint'(m);
        sum = neg ? sum - delta : sum + delta;
        tone_ph = tone_ph + (tone_acc ? cfg_m.accent_phase_step : cfg_m.normal_phase_step);
        m = 64'(env_lvl);
        m = (m * cfg_m.decay_factor) >> 16;
        env_lvl = m[15:0];
        cnt = tone_cnt + 1;
        if (cnt >= cfg_m.click_length) tone_on = 1'b0;
        tone_cnt = cnt[15:0];
      end
    end
    if (sum > SMP_MAX) sum = SMP_MAX;
    if (sum < SMP_MIN) sum = SMP_MIN;
    r.out_sample = sum[SMP_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("tb_top: mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  function automatic bit sender_idle();
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 81 : ((idle_mode == IDLE_BOTH) ? 30 : 0);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit receiver_stall();
    int pct;
    pct = (idle_mode == IDLE_RECV) ? 81 : ((idle_mode == IDLE_BOTH) ? 30 : 0);
    return $urandom_range(99) < pct;
  endfunction

  // Hold off until every expected result is in and the block has settled
  task automatic quiesce();
    if (!cfg_open) begin
      smp_if.valid <= 1'b0;
      while (mix_expect_q.size() != 0 || sent_tag_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYC) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // Write one register while the block is idle; mirror it in the predictor
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ENABLE:            cfg_m.enable            = val[0];
      REG_SAMPLES_PER_BEAT:  cfg_m.samples_per_beat  = val;
      REG_BEATS_PER_BAR:     cfg_m.beats_per_bar     = val[6:0];
      REG_CLICK_GAIN:        cfg_m.click_gain        = val[15:0];
      REG_CLICK_LENGTH:      cfg_m.click_length      = val[15:0];
      REG_DECAY_FACTOR:      cfg_m.decay_factor      = val[15:0];
      REG_ACCENT_PHASE_STEP: cfg_m.accent_phase_step = val;
      REG_NORMAL_PHASE_STEP: cfg_m.normal_phase_step = val;
      default: ;
    endcase
    cfg_open = 1'b1;
    @(negedge clk);
  endtask

  // Offer one sample request and wait for it to be taken; called at a falling edge
  task automatic push_sample(input logic signed [SMP_W-1:0] x, input bit typed,
                             input mix_t want);
    stim_tag_t tag;
    if (cfg_open) begin
      cfg_wr_en <= 1'b0;
      cfg_open = 1'b0;
    end
    while (sender_idle()) begin
      smp_if.valid <= 1'b0;
      @(negedge clk);
    end
    tag.typed = typed;
    tag.want  = want;
    sent_tag_q.push_back(tag);
    smp_if.valid     <= 1'b1;
    smp_if.in_sample <= x;
    do @(posedge clk); while (!(smp_if.valid && smp_if.ready));
    @(negedge clk);
  endtask

  function automatic void row_cfg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_smp(input logic signed [SMP_W-1:0] x, input bit typed,
                                  input logic signed [SMP_W-1:0] out, input bit st,
                                  input bit acc);
    dir_row_t r;
    r = '0;
    r.smp   = x;
    r.typed = typed;
    r.want.out_sample    = out;
    r.want.click_started = st;
    r.want.accent_beat   = acc;
    dir_rows.push_back(r);
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    int v;
    v = 0;
    case ($urandom_range(9))
      0: v = int'(SMP_MAX);
      1: v = int'(SMP_MIN);
      2: v = int'($urandom_range(512)) - 256;
      3: v = int'($urandom_range(65536)) - 32768;
      default: v = $urandom();
    endcase
    return v[SMP_W-1:0];
  endfunction

  // Program every register with a mix of extremes and useful ranges
  task automatic program_random_regs();
    logic [31:0] spb, bpb, gain, len, dec, ast, nst;
    case ($urandom_range(9))
      0: spb = 32'd0;
      1: spb = $urandom_range(255, 1);
      2: spb = 32'hFFFF_FFFF;
      3: spb = MIN_PERIOD;
      default: spb = $urandom_range(256 * 24, 256);
    endcase
    case ($urandom_range(7))
      0: bpb = 32'd0;
      1: bpb = $urandom_range(127, 65);
      2: bpb = 32'(MAX_BPB);
      3: bpb = 32'd1;
      default: bpb = $urandom_range(8, 1);
    endcase
    case ($urandom_range(4))
      0: gain = 32'd0;
      1: gain = 32'hFFFF;
      default: gain = $urandom_range(65535);
    endcase
    case ($urandom_range(5))
      0: len = 32'd0;
      1: len = 32'd1;
      2: len = 32'hFFFF;
      default: len = $urandom_range(32, 1);
    endcase
    case ($urandom_range(4))
      0: dec = 32'd0;
      1: dec = 32'hFFFF;
      2: dec = $urandom_range(65535);
      default: dec = $urandom_range(65535, 60000);
    endcase
    case ($urandom_range(4))
      0: ast = 32'd0;
      1: ast = 32'hFFFF_FFFF;
      default: ast = $urandom();
    endcase
    case ($urandom_range(4))
      0: nst = 32'd0;
      1: nst = 32'hFFFF_FFFF;
      default: nst = $urandom();
    endcase
    write_reg(REG_ENABLE, ($urandom_range(7) != 0) ? 32'd1 : 32'd0);
    write_reg(REG_SAMPLES_PER_BEAT, spb);
    write_reg(REG_BEATS_PER_BAR, bpb);
    write_reg(REG_CLICK_GAIN, gain);
    write_reg(REG_CLICK_LENGTH, len);
    write_reg(REG_DECAY_FACTOR, dec);
    write_reg(REG_ACCENT_PHASE_STEP, ast);
    write_reg(REG_NORMAL_PHASE_STEP, nst);
  endtask

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Fill the predictor table and reset state
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) sine_tab[i] = quarter_sine(i);
    cfg_m.enable            = 1'b0;
    cfg_m.samples_per_beat  = RST_SAMPLES_PER_BEAT;
    cfg_m.beats_per_bar     = RST_BEATS_PER_BAR;
    cfg_m.click_gain        = RST_CLICK_GAIN;
    cfg_m.click_length      = RST_CLICK_LENGTH;
    cfg_m.decay_factor      = RST_DECAY_FACTOR;
    cfg_m.accent_phase_step = RST_ACCENT_PHASE_STEP;
    cfg_m.normal_phase_step = RST_NORMAL_PHASE_STEP;
    begun_q  = 1'b0;
    beat_acc = '0;
    bar_pos  = '0;
    tone_on  = 1'b0;
    tone_cnt = '0;
    tone_ph  = '0;
    env_lvl  = '0;
    tone_acc = 1'b0;
  end

  // Cycle counter and run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: timeout after %0d cycles", cycle_cnt);
    $display("tb_top: done, errors");
    $finish;
  end

  // Receiver: drop ready at random per the idle mode
  always @(negedge clk) begin
    res_if.ready <= !receiver_stall();
  end

  // Predict each accepted sample request
  always @(posedge clk) begin : take_request
    stim_tag_t tag;
    mix_t      got;
    if (!rst && smp_if.valid && smp_if.ready) begin
      got = click_mix_predict(smp_if.in_sample);
      if (sent_tag_q.size() == 0) begin
        flag_mismatch("sample accepted with no request offered");
      end else begin
        tag = sent_tag_q.pop_front();
        mix_expect_q.push_back(tag.typed ? tag.want : got);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_result
    mix_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (mix_expect_q.size() == 0) begin
        flag_mismatch("result with nothing expected");
      end else begin
        want = mix_expect_q.pop_front();
        if (res_if.out_sample !== want.out_sample)
          flag_mismatch($sformatf("out_sample %0d, expected %0d",
                                  res_if.out_sample, want.out_sample));
        if (res_if.click_started !== want.click_started)
          flag_mismatch($sformatf("click_started %b, expected %b",
                                  res_if.click_started, want.click_started));
        if (res_if.accent_beat !== want.accent_beat)
          flag_mismatch($sformatf("accent_beat %b, expected %b",
                                  res_if.accent_beat, want.accent_beat));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    mismatch_cnt = 0;
    cfg_open     = 1'b0;
    idle_mode    = IDLE_NONE;
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    smp_if.valid     <= 1'b0;
    smp_if.in_sample <= '0;

    // Disabled after reset: samples pass through untouched
    row_smp(24'sh000000, 1, 24'sh000000, 0, 0);
    row_smp(24'sh7FFFFF, 1, 24'sh7FFFFF, 0, 0);
    row_smp(24'sh800000, 1, 24'sh800000, 0, 0);
    row_smp(24'sh555555, 1, 24'sh555555, 0, 0);
    // Enable: the first sample starts an accented click at phase zero
    row_cfg(REG_ENABLE, 32'd1);
    row_cfg(REG_SAMPLES_PER_BEAT, 32'd768);
    row_cfg(REG_BEATS_PER_BAR, 32'd2);
    row_cfg(REG_CLICK_LENGTH, 32'd8);
    row_smp(24'sd100, 1, 24'sd100, 1, 1);
    row_smp(-24'sd200, 0, '0, 0, 0);
    row_smp(24'sh7FFFFF, 0, '0, 0, 0);
    row_smp(24'sh800000, 0, '0, 0, 0);
    row_smp(24'sh2AAAAA, 0, '0, 0, 0);
    // Full gain, a quarter-turn accent step and a three-quarter-turn normal step drive the sum into saturation
    row_cfg(REG_CLICK_GAIN, 32'hFFFF);
    row_cfg(REG_ACCENT_PHASE_STEP, 32'h4000_0000);
    row_cfg(REG_NORMAL_PHASE_STEP, 32'hC000_0000);
    row_smp(24'sh7FFFFF, 0, '0, 0, 0);
    row_smp(24'sh800000, 0, '0, 0, 0);
    // Short period acts as one sample; then shrink the bar under the counter
    row_cfg(REG_SAMPLES_PER_BEAT, 32'd1);
    row_cfg(REG_BEATS_PER_BAR, 32'd5);
    row_smp(24'sd0, 0, '0, 0, 0);
    row_smp(24'sd0, 0, '0, 0, 0);
    row_smp(24'sd0, 0, '0, 0, 0);
    row_cfg(REG_BEATS_PER_BAR, 32'd2);
    row_smp(24'sd0, 0, '0, 0, 0);
    // Bar size of zero and above the cap
    row_cfg(REG_BEATS_PER_BAR, 32'd0);
    row_smp(24'sd1, 0, '0, 0, 0);
    row_cfg(REG_BEATS_PER_BAR, 32'd127);
    row_smp(-24'sd1, 0, '0, 0, 0);
    // Zero length, then a long click cut short while it sounds
    row_cfg(REG_CLICK_LENGTH, 32'd0);
    row_cfg(REG_DECAY_FACTOR, 32'hFFFF);
    row_smp(24'sh400000, 0, '0, 0, 0);
    row_cfg(REG_CLICK_LENGTH, 32'hFFFF);
    row_cfg(REG_DECAY_FACTOR, 32'd0);
    row_smp(24'sd0, 0, '0, 0, 0);
    row_cfg(REG_SAMPLES_PER_BEAT, 32'hFFFF_FFFF);
    row_smp(24'sd0, 0, '0, 0, 0);
    row_smp(24'sd0, 0, '0, 0, 0);
    row_cfg(REG_CLICK_LENGTH, 32'd2);
    row_smp(24'sd7, 0, '0, 0, 0);
    // Zero period behaves as disabled, as does enable low
    row_cfg(REG_SAMPLES_PER_BEAT, 32'd0);
    row_smp(24'sh2AAAAA, 1, 24'sh2AAAAA, 0, 0);
    row_cfg(REG_ENABLE, 32'd0);
    row_cfg(REG_SAMPLES_PER_BEAT, 32'd256);
    row_smp(24'shAAAAAA, 1, 24'shAAAAAA, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_reg(dir_rows[k].idx, dir_rows[k].val);
      else push_sample(dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases, each with fresh registers and its own idle pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      program_random_regs();
      idle_mode = idle_mode_t'(ph % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) push_sample(pick_sample(), 1'b0, '0);
    end

    // Drain and settle
    smp_if.valid <= 1'b0;
    while (mix_expect_q.size() != 0 || sent_tag_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mcg_pkg.sv
design/mcg_stream_if.sv
design/mcg_mul.sv
design/mcg_sine_rom.sv
design/mcg_ctrl.sv
design/metronome_click_generator_core.sv
sim/tb_top.sv
